@@ rtl/core/vsrs_pkg.sv @@
package vsrs_pkg;

    localparam int UV_W       = 22;
    localparam int DUTY_W     = 7;
    localparam int IDX_W      = 7;
    localparam int STEP_W     = 17;
    localparam int EIDX_W     = 5;
    localparam int TC_W       = 6;
    localparam int PROD_W     = IDX_W + STEP_W;
    localparam int TBL_W      = UV_W + DUTY_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;

    localparam logic [UV_W-1:0] UV_MAX = {UV_W{1'b1}};

    // Top bit position of the regulator step quotient
    localparam logic [2:0] Q_TOP = 3'(IDX_W - 1);

    localparam logic FUNC_WRITE   = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_BAD_DOMAIN  = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
    localparam logic [1:0] ST_BAD_ENTRY   = 2'd3;

    localparam logic [1:0] MODE_TABLE  = 2'd0;
    localparam logic [1:0] MODE_LINEAR = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_LITTLE_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIG_MODE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VREG_MIN_UV    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VREG_STEP_UV   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VREG_NUM_STEPS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_COUNT    = 3'd5;

    typedef struct packed {
        logic              little_mode;
        logic [1:0]        big_mode;
        logic [UV_W-1:0]   vreg_min_uv;
        logic [STEP_W-1:0] vreg_step_uv;
        logic [IDX_W-1:0]  vreg_num_steps;
        logic [TC_W-1:0]   table_count;
    } cfg_t;

endpackage

@@ rtl/core/vsrs_ram.sv @@
module vsrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/vsrs_cfg.sv @@
module vsrs_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [vsrs_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [vsrs_pkg::CFG_DATA_W-1:0]  wr_data,
    output vsrs_pkg::cfg_t                   cfg
);

    vsrs_pkg::cfg_t cfg_reg;
    vsrs_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                vsrs_pkg::CFG_LITTLE_MODE:    cfg_next.little_mode    = wr_data[0];
                vsrs_pkg::CFG_BIG_MODE:       cfg_next.big_mode       = wr_data[1:0];
                vsrs_pkg::CFG_VREG_MIN_UV:
                    cfg_next.vreg_min_uv = wr_data[vsrs_pkg::UV_W-1:0];
                vsrs_pkg::CFG_VREG_STEP_UV:
                    cfg_next.vreg_step_uv = wr_data[vsrs_pkg::STEP_W-1:0];
                vsrs_pkg::CFG_VREG_NUM_STEPS:
                    cfg_next.vreg_num_steps = wr_data[vsrs_pkg::IDX_W-1:0];
                vsrs_pkg::CFG_TABLE_COUNT:
                    cfg_next.table_count = wr_data[vsrs_pkg::TC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.little_mode    <= 1'b0;
            cfg_reg.big_mode       <= 2'd2;
            cfg_reg.vreg_min_uv    <= '0;
            cfg_reg.vreg_step_uv   <= vsrs_pkg::STEP_W'(1);
            cfg_reg.vreg_num_steps <= '0;
            cfg_reg.table_count    <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/core/vsrs_div.sv @@
module vsrs_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [vsrs_pkg::UV_W-1:0]     dividend,
    input  logic [vsrs_pkg::STEP_W-1:0]   divisor,
    output logic                          done,
    output logic [vsrs_pkg::IDX_W-1:0]    quotient
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [2:0]                    k_reg;
    logic [vsrs_pkg::UV_W-1:0]     rem_reg;
    logic [vsrs_pkg::IDX_W-1:0]    q_reg;
    logic [vsrs_pkg::PROD_W-1:0]   shifted;
    logic                          fits;

    // Restoring division, one quotient bit per cycle, top bit first
    assign shifted = vsrs_pkg::PROD_W'(divisor) << k_reg;
    assign fits    = vsrs_pkg::PROD_W'(rem_reg) >= shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (k_reg == 3'd0);
            if (start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= vsrs_pkg::Q_TOP;
            end
            else if (busy_reg)
            begin
                if (k_reg == 3'd0)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    k_reg <= k_reg - 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= vsrs_pkg::UV_W'(vsrs_pkg::PROD_W'(rem_reg) - shifted);
            end
            q_reg <= {q_reg[vsrs_pkg::IDX_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

@@ rtl/core/voltage_step_ramp_sequencer.sv @@
// A table write or an error answers with a single output; a table request
// does one table RAM read per entry with a pipelined compare; a regulator
// request runs the bit-serial divider. Each ramp step then passes through
// the step, RAM read or multiply, and output states.
// One transaction at a time; reset clears control, config and domain state,
// the voltage table holds garbage until written.
module voltage_step_ramp_sequencer #(
    parameter int TABLE_DEPTH = 32,
    parameter int MAX_STEP    = 3
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vsrs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vsrs_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              func,
    input  logic                              domain_sel,
    input  logic [vsrs_pkg::EIDX_W-1:0]       entry_index,
    input  logic [vsrs_pkg::UV_W-1:0]         entry_uv,
    input  logic [vsrs_pkg::DUTY_W-1:0]       entry_duty,
    input  logic [vsrs_pkg::UV_W-1:0]         target_uv,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              out_domain,
    output logic [vsrs_pkg::IDX_W-1:0]        step_index,
    output logic [vsrs_pkg::DUTY_W-1:0]       duty_cycle,
    output logic [vsrs_pkg::UV_W-1:0]         actual_uv,
    output logic                              drive,
    output logic [1:0]                        status,
    output logic                              last
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [7:0] DEPTH_C = 8'(TABLE_DEPTH);
    localparam logic [7:0] STEP_C  = 8'(MAX_STEP);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SEARCH  = 4'd1;
    localparam logic [3:0] S_LMUL    = 4'd2;
    localparam logic [3:0] S_LCHK    = 4'd3;
    localparam logic [3:0] S_LDIV    = 4'd4;
    localparam logic [3:0] S_RESOLVE = 4'd5;
    localparam logic [3:0] S_STEP    = 4'd6;
    localparam logic [3:0] S_VREAD   = 4'd7;
    localparam logic [3:0] S_VOUT    = 4'd8;
    localparam logic [3:0] S_SINGLE  = 4'd9;

    vsrs_pkg::cfg_t cfg;

    logic [3:0]                      state_reg, state_next;
    logic                            pend_reg, pend_next;
    logic [1:0]                      idx_valid_reg, idx_valid_next;
    logic                            out_valid_reg;

    logic                            dom_reg, dom_next;
    logic [vsrs_pkg::UV_W-1:0]       tuv_reg, tuv_next;
    logic                            is_lin_reg, is_lin_next;
    logic [CW-1:0]                   cnt_reg, cnt_next;
    logic [CW-1:0]                   i_reg, i_next;
    logic [vsrs_pkg::IDX_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic [vsrs_pkg::IDX_W-1:0]      tgt_reg, tgt_next;
    logic [vsrs_pkg::IDX_W-1:0]      cur_reg, cur_next;
    logic                            drive_reg, drive_next;
    logic                            oob_reg, oob_next;
    logic                            sdom_reg, sdom_next;
    logic [1:0]                      sstatus_reg, sstatus_next;
    logic [vsrs_pkg::PROD_W-1:0]     prod_reg, prod_next;

    logic                            out_domain_reg;
    logic [vsrs_pkg::IDX_W-1:0]      step_index_reg;
    logic [vsrs_pkg::DUTY_W-1:0]     duty_cycle_reg;
    logic [vsrs_pkg::UV_W-1:0]       actual_uv_reg;
    logic                            drive_out_reg;
    logic [1:0]                      status_reg;
    logic                            last_reg;

    logic                            tbl_we, tbl_re;
    logic [AW-1:0]                   tbl_raddr;
    logic [vsrs_pkg::TBL_W-1:0]      tbl_rdata;
    logic [vsrs_pkg::UV_W-1:0]       tbl_volts;
    logic [vsrs_pkg::DUTY_W-1:0]     tbl_duty;

    logic                            cidx_re, cidx_we;
    logic [vsrs_pkg::IDX_W-1:0]      cidx_rdata;

    logic                            div_start, div_done;
    logic [vsrs_pkg::IDX_W-1:0]      div_q;

    logic                            accept;
    logic                            emit, push;
    logic                            e_dom, e_drive, e_last;
    logic [vsrs_pkg::IDX_W-1:0]      e_idx;
    logic [vsrs_pkg::DUTY_W-1:0]     e_duty;
    logic [vsrs_pkg::UV_W-1:0]       e_uv;
    logic [1:0]                      e_status;

    logic [1:0]                      req_mode;
    logic [7:0]                      tc8, c8, t8;
    logic [vsrs_pkg::UV_W+2:0]       hi_uv, lin_sum;

    vsrs_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    vsrs_ram #(
        .WIDTH (vsrs_pkg::TBL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (AW'(entry_index)),
        .wdata ({entry_uv, entry_duty}),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    vsrs_ram #(
        .WIDTH (vsrs_pkg::IDX_W),
        .DEPTH (2)
    ) u_cur_idx (
        .clk   (clk),
        .we    (cidx_we),
        .waddr (dom_reg),
        .wdata (tgt_reg),
        .re    (cidx_re),
        .raddr (domain_sel),
        .rdata (cidx_rdata)
    );

    vsrs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (vsrs_pkg::UV_W'(tuv_reg - cfg.vreg_min_uv)),
        .divisor  (cfg.vreg_step_uv),
        .done     (div_done),
        .quotient (div_q)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign push      = emit && (!out_valid_reg || out_ready);

    assign tbl_volts = tbl_rdata[vsrs_pkg::TBL_W-1:vsrs_pkg::DUTY_W];
    assign tbl_duty  = tbl_rdata[vsrs_pkg::DUTY_W-1:0];

    // Source of the addressed domain: little is table or regulator, big may be absent
    assign req_mode = domain_sel ? cfg.big_mode : {1'b0, cfg.little_mode};
    assign tc8      = 8'(cfg.table_count);
    assign c8       = {1'b0, cur_reg};
    assign t8       = {1'b0, tgt_reg};
    assign hi_uv    = {3'b0, cfg.vreg_min_uv} + {1'b0, prod_reg};
    assign lin_sum  = {3'b0, cfg.vreg_min_uv} + {1'b0, prod_reg};

    always_comb
    begin
        state_next     = state_reg;
        pend_next      = pend_reg;
        idx_valid_next = idx_valid_reg;
        dom_next       = dom_reg;
        tuv_next       = tuv_reg;
        is_lin_next    = is_lin_reg;
        cnt_next       = cnt_reg;
        i_next         = i_reg;
        cmp_idx_next   = cmp_idx_reg;
        tgt_next       = tgt_reg;
        cur_next       = cur_reg;
        drive_next     = drive_reg;
        oob_next       = oob_reg;
        sdom_next      = sdom_reg;
        sstatus_next   = sstatus_reg;
        prod_next      = prod_reg;
        tbl_we         = 1'b0;
        tbl_re         = 1'b0;
        tbl_raddr      = AW'(cur_reg);
        cidx_re        = 1'b0;
        cidx_we        = 1'b0;
        div_start      = 1'b0;
        emit           = 1'b0;
        e_dom          = sdom_reg;
        e_idx          = '0;
        e_duty         = '0;
        e_uv           = '0;
        e_drive        = 1'b0;
        e_status       = sstatus_reg;
        e_last         = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    dom_next     = domain_sel;
                    tuv_next     = target_uv;
                    i_next       = '0;
                    pend_next    = 1'b0;
                    cnt_next     = CW'((tc8 > DEPTH_C) ? DEPTH_C : tc8);
                    cidx_re      = 1'b1;
                    sdom_next    = domain_sel;
                    sstatus_next = vsrs_pkg::ST_OK;
                    if (func == vsrs_pkg::FUNC_WRITE)
                    begin
                        sdom_next  = 1'b0;
                        state_next = S_SINGLE;
                        if (8'(entry_index) >= DEPTH_C)
                        begin
                            sstatus_next = vsrs_pkg::ST_BAD_ENTRY;
                        end
                        else
                        begin
                            tbl_we = 1'b1;
                        end
                    end
                    else if (req_mode == vsrs_pkg::MODE_TABLE)
                    begin
                        is_lin_next = 1'b0;
                        state_next  = S_SEARCH;
                    end
                    else if (req_mode == vsrs_pkg::MODE_LINEAR)
                    begin
                        is_lin_next = 1'b1;
                        state_next  = S_LMUL;
                    end
                    else
                    begin
                        sstatus_next = vsrs_pkg::ST_BAD_DOMAIN;
                        state_next   = S_SINGLE;
                    end
                end
            end

            S_SEARCH:
            begin
                // Compare the entry read last cycle while the next read goes out
                tbl_raddr = AW'(i_reg);
                if (pend_reg && (tbl_volts <= tuv_reg))
                begin
                    tgt_next   = cmp_idx_reg;
                    pend_next  = 1'b0;
                    state_next = S_RESOLVE;
                end
                else if (i_reg == cnt_reg)
                begin
                    pend_next    = 1'b0;
                    sstatus_next = vsrs_pkg::ST_UNSUPPORTED;
                    state_next   = S_SINGLE;
                end
                else
                begin
                    tbl_re       = 1'b1;
                    cmp_idx_next = vsrs_pkg::IDX_W'(i_reg);
                    i_next       = i_reg + CW'(1);
                    pend_next    = 1'b1;
                end
            end

            S_LMUL:
            begin
                prod_next  = vsrs_pkg::PROD_W'(cfg.vreg_num_steps)
                           * vsrs_pkg::PROD_W'(cfg.vreg_step_uv);
                state_next = S_LCHK;
            end

            S_LCHK:
            begin
                if ((tuv_reg < cfg.vreg_min_uv) || ({3'b0, tuv_reg} > hi_uv))
                begin
                    sstatus_next = vsrs_pkg::ST_UNSUPPORTED;
                    state_next   = S_SINGLE;
                end
                else if (cfg.vreg_step_uv == '0)
                begin
                    tgt_next   = '0;
                    state_next = S_RESOLVE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_LDIV;
                end
            end

            S_LDIV:
            begin
                if (div_done)
                begin
                    tgt_next   = div_q;
                    state_next = S_RESOLVE;
                end
            end

            S_RESOLVE:
            begin
                // The domain ends on the target either way: write it back now
                cidx_we                 = 1'b1;
                idx_valid_next[dom_reg] = 1'b1;
                if (idx_valid_reg[dom_reg] && (cidx_rdata != tgt_reg))
                begin
                    cur_next   = cidx_rdata;
                    drive_next = 1'b1;
                    state_next = S_STEP;
                end
                else
                begin
                    cur_next   = tgt_reg;
                    drive_next = !idx_valid_reg[dom_reg];
                    state_next = S_VREAD;
                end
            end

            S_STEP:
            begin
                if (c8 < t8)
                begin
                    cur_next = vsrs_pkg::IDX_W'(((c8 + STEP_C) < t8) ? (c8 + STEP_C) : t8);
                end
                else
                begin
                    cur_next = vsrs_pkg::IDX_W'((c8 > (t8 + STEP_C)) ? (c8 - STEP_C) : t8);
                end
                state_next = S_VREAD;
            end

            S_VREAD:
            begin
                oob_next   = c8 >= DEPTH_C;
                tbl_re     = !is_lin_reg && (c8 < DEPTH_C);
                prod_next  = vsrs_pkg::PROD_W'(cur_reg) * vsrs_pkg::PROD_W'(cfg.vreg_step_uv);
                state_next = S_VOUT;
            end

            S_VOUT:
            begin
                emit     = 1'b1;
                e_dom    = dom_reg;
                e_idx    = cur_reg;
                e_drive  = drive_reg;
                e_status = vsrs_pkg::ST_OK;
                e_last   = (cur_reg == tgt_reg);
                if (is_lin_reg)
                begin
                    e_uv = (lin_sum > {3'b0, vsrs_pkg::UV_MAX}) ? vsrs_pkg::UV_MAX
                                                               : lin_sum[vsrs_pkg::UV_W-1:0];
                end
                else if (!oob_reg)
                begin
                    e_duty = tbl_duty;
                    e_uv   = tbl_volts;
                end
                if (push)
                begin
                    state_next = e_last ? S_IDLE : S_STEP;
                end
            end

            S_SINGLE:
            begin
                emit = 1'b1;
                if (push)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            idx_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            idx_valid_reg <= idx_valid_next;
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dom_reg     <= dom_next;
        tuv_reg     <= tuv_next;
        is_lin_reg  <= is_lin_next;
        cnt_reg     <= cnt_next;
        i_reg       <= i_next;
        cmp_idx_reg <= cmp_idx_next;
        tgt_reg     <= tgt_next;
        cur_reg     <= cur_next;
        drive_reg   <= drive_next;
        oob_reg     <= oob_next;
        sdom_reg    <= sdom_next;
        sstatus_reg <= sstatus_next;
        prod_reg    <= prod_next;
        if (push)
        begin
            out_domain_reg <= e_dom;
            step_index_reg <= e_idx;
            duty_cycle_reg <= e_duty;
            actual_uv_reg  <= e_uv;
            drive_out_reg  <= e_drive;
            status_reg     <= e_status;
            last_reg       <= e_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_domain = out_domain_reg;
    assign step_index = step_index_reg;
    assign duty_cycle = duty_cycle_reg;
    assign actual_uv  = actual_uv_reg;
    assign drive      = drive_out_reg;
    assign status     = status_reg;
    assign last       = last_reg;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("transaction accepted but sequencer stayed idle");

    a_table_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_we |-> (state_reg == S_IDLE) && accept)
        else $error("table written outside an accepted transaction");

    a_ramp_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STEP) |=>
            ((({1'b0, cur_reg} >= {1'b0, $past(cur_reg)})
                ? ({1'b0, cur_reg} - {1'b0, $past(cur_reg)})
                : ({1'b0, $past(cur_reg)} - {1'b0, cur_reg})) <= STEP_C))
        else $error("ramp step larger than the slew limit");

    a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((idx_valid_reg & $past(idx_valid_reg)) == $past(idx_valid_reg)))
        else $error("domain index valid bit dropped");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_LDIV))
        else $error("divider finished while not awaited");

endmodule
